// ----- hdl/jen_pkg.sv -----
// shared types, constants and codes for the joystick event normalizer
package jen_pkg;

    localparam int KEY_CODES    = 768;
    localparam int AXIS_CODES   = 64;
    localparam int BUTTON_LIMIT = 32;
    localparam int AXIS_LIMIT   = 32;

    localparam int KEY_AW  = (KEY_CODES > 1) ? $clog2(KEY_CODES) : 1;
    localparam int AXC_AW  = (AXIS_CODES > 1) ? $clog2(AXIS_CODES) : 1;
    localparam int BTN_IW  = (BUTTON_LIMIT > 1) ? $clog2(BUTTON_LIMIT) : 1;
    localparam int AXL_IW  = (AXIS_LIMIT > 1) ? $clog2(AXIS_LIMIT) : 1;

    // key map entry: valid bit over a 7-bit logical index
    localparam int KEY_MAP_W  = 8;
    // axis entry: index, maximum, minimum
    localparam int AXIS_MAP_W = 7 + 32 + 32;

    // quotient bits produced by the divider, two above the 16 we keep
    localparam int DIV_STEPS = 18;
    localparam int DIV_CW    = $clog2(DIV_STEPS);
    localparam int NUM_W     = 48;
    localparam int DEN_W     = 32;

    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 24;

    typedef enum logic [2:0] {
        KIND_KEY      = 3'd0,
        KIND_AXIS     = 3'd1,
        KIND_OTHER    = 3'd2,
        KIND_KEY_CAP  = 3'd3,
        KIND_AXIS_CAP = 3'd4,
        KIND_DEADZONE = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_BUTTON = 2'd1,
        EV_AXIS   = 2'd2
    } ev_kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_PREP,
        ST_NUM,
        ST_DIV,
        ST_FINISH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [15:0] quot;
        logic        rem_nz;
    } div_res_t;

endpackage

// ----- hdl/joystick_event_normalizer.sv -----
// top level of the joystick event normalizer: sequencer, state and result register
//
//  channel  | group                      | content
//  ---------+----------------------------+-----------------------------------------
//  input    | s_tvalid s_tready s_tdata  | event or capability word, kind on s_tuser
//           | s_tuser                    |
//  result   | m_tvalid m_tready m_tdata  | button or axis change, event kind on m_tuser
//           | m_tuser                    |
//
// after reset every key map entry is swept clear, with s_tready low
// a word that reports nothing passes through lookup only; a key change adds emit
// an axis word passes through lookup, the setup states prep and num, the divide state,
// finish and emit; the deadzone drop ends at finish, and a result pinned at the minimum
// goes from num straight to finish without the divide state
// a result waits in the output register; a stalled m_tready holds only a new result
module joystick_event_normalizer
    import jen_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // code[9:0], event_value[41:10], present[42], range_low[74:43],
    // range_high[106:75], dead_band[122:107], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind[2:0]
    input  logic [2:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // logical_index[4:0], axis_level[20:5], button_level[22:21], zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // event_kind[1:0]
    output logic [1:0]           m_tuser
);

    state_t state_reg, state_next;

    // accepted word
    kind_t        kind_reg;
    logic [9:0]   code_reg;
    logic [31:0]  value_reg;
    logic         present_reg;
    logic [31:0]  lo_reg;
    logic [31:0]  hi_reg;
    logic [15:0]  band_reg;

    logic [KEY_AW-1:0] clr_cnt_reg;
    logic [9:0]        next_btn_reg;
    logic [6:0]        next_axis_reg;

    logic [1:0]  btn_state_reg [BUTTON_LIMIT];
    logic        axis_nz_reg   [AXIS_LIMIT];
    logic [15:0] dead_reg      [AXIS_LIMIT];
    logic        axis_valid_reg [AXIS_CODES];

    // axis datapath
    logic [AXL_IW-1:0] aidx_reg;
    logic signed [32:0] diff_reg, den_reg;
    logic [31:0] absd_reg, absn_reg;
    logic        zero_reg;

    // pending result
    ev_kind_t    res_kind_reg;
    logic [4:0]  res_idx_reg;
    logic [15:0] res_axis_reg;
    logic [1:0]  res_btn_reg;

    // output register
    logic        m_valid_reg;
    ev_kind_t    m_kind_reg;
    logic [4:0]  m_idx_reg;
    logic [15:0] m_axis_reg;
    logic [1:0]  m_btn_reg;

    // memories
    logic                  key_we;
    logic [KEY_AW-1:0]     key_waddr;
    logic [KEY_MAP_W-1:0]  key_wdata;
    logic [KEY_MAP_W-1:0]  key_rdata;
    logic                  axis_we;
    logic [AXIS_MAP_W-1:0] axis_rdata;

    div_res_t    div_res;
    logic        div_start;
    logic [NUM_W-1:0] num;

    logic        accept, out_free;
    logic        key_in_range, axis_in_range, key_hit, axis_hit;
    logic [6:0]  key_idx, axis_idx;
    logic [BTN_IW-1:0] btn_idx;
    logic [AXC_AW-1:0] axis_code;
    logic [1:0]  lvl;
    logic        lvl_changed;
    logic [31:0] a_min, a_max;
    logic signed [32:0] diff_c, den_c;
    logic [15:0] scaled;
    logic [16:0] mag;
    logic        below, drop;
    logic [15:0] final_level;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    jen_ram #(.WIDTH(KEY_MAP_W), .DEPTH(KEY_CODES)) u_key_map (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (accept),
        .raddr (s_tdata[KEY_AW-1:0]),
        .rdata (key_rdata)
    );

    jen_ram #(.WIDTH(AXIS_MAP_W), .DEPTH(AXIS_CODES)) u_axis_map (
        .aclk  (aclk),
        .we    (axis_we),
        .waddr (code_reg[AXC_AW-1:0]),
        .wdata ({(next_axis_reg), hi_reg, lo_reg}),
        .re    (accept),
        .raddr (s_tdata[AXC_AW-1:0]),
        .rdata (axis_rdata)
    );

    jen_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num),
        .divisor  (absn_reg),
        .res      (div_res)
    );

    // lookup decode
    assign key_in_range  = {1'b0, code_reg} < 11'(KEY_CODES);
    assign axis_in_range = {1'b0, code_reg} < 11'(AXIS_CODES);
    assign key_idx       = key_rdata[6:0];
    assign btn_idx       = key_idx[BTN_IW-1:0];
    assign key_hit       = key_in_range && key_rdata[7] && (key_idx < 7'(BUTTON_LIMIT));
    assign axis_code     = code_reg[AXC_AW-1:0];
    assign axis_idx      = axis_rdata[70:64];
    assign a_max         = axis_rdata[63:32];
    assign a_min         = axis_rdata[31:0];
    assign axis_hit      = axis_in_range && axis_valid_reg[axis_code]
                           && (axis_idx < 7'(AXIS_LIMIT));
    assign lvl = value_reg[31] ? 2'd0 : ((|value_reg[30:2]) ? 2'd3 : value_reg[1:0]);
    assign lvl_changed = btn_state_reg[btn_idx] != lvl;
    assign diff_c = $signed({value_reg[31], value_reg}) - $signed({a_min[31], a_min});
    assign den_c  = $signed({a_max[31], a_max}) - $signed({a_min[31], a_min});

    // |v-min| * 65535 without a multiplier
    assign num = {absd_reg, 16'd0} - {16'd0, absd_reg};

    // truncate (q - 32768) toward zero, q >= 0 here
    always_comb begin
        if (zero_reg) begin
            scaled = 16'h8000;
        end else if (div_res.ovf) begin
            scaled = 16'h7fff;
        end else begin
            scaled = {~div_res.quot[15], div_res.quot[14:0]}
                     + {15'd0, ~div_res.quot[15] & div_res.rem_nz};
        end
    end

    assign mag   = scaled[15] ? (17'd0 - {1'b1, scaled}) : {1'b0, scaled};
    assign below = mag < {1'b0, dead_reg[aidx_reg]};
    assign drop  = below && !axis_nz_reg[aidx_reg];
    assign final_level = below ? 16'd0 : scaled;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == KEY_AW'(KEY_CODES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                case (kind_reg)
                    KIND_KEY:  state_next = (key_hit && lvl_changed) ? ST_EMIT : ST_IDLE;
                    KIND_AXIS: state_next = axis_hit ? ST_PREP : ST_IDLE;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_PREP:   state_next = ST_NUM;
            ST_NUM:    state_next = zero_reg ? ST_FINISH : ST_DIV;
            ST_DIV: begin
                if (div_res.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: state_next = drop ? ST_IDLE : ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready  = 1'b0;
        key_we    = 1'b0;
        key_waddr = code_reg[KEY_AW-1:0];
        key_wdata = {1'b1, (next_btn_reg > 10'd127) ? 7'd127 : next_btn_reg[6:0]};
        axis_we   = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                key_we    = 1'b1;
                key_waddr = clr_cnt_reg;
                key_wdata = '0;
            end
            ST_IDLE:  s_tready = 1'b1;
            ST_LOOKUP: begin
                key_we  = (kind_reg == KIND_KEY_CAP) && key_in_range && present_reg;
                axis_we = (kind_reg == KIND_AXIS_CAP) && axis_in_range && present_reg;
            end
            ST_NUM:   div_start = !zero_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            next_btn_reg  <= '0;
            next_axis_reg <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < BUTTON_LIMIT; i++) begin
                btn_state_reg[i] <= '0;
            end
            for (int i = 0; i < AXIS_LIMIT; i++) begin
                axis_nz_reg[i] <= 1'b0;
                dead_reg[i]    <= '0;
            end
            for (int i = 0; i < AXIS_CODES; i++) begin
                axis_valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == ST_LOOKUP) begin
                case (kind_reg)
                    KIND_KEY: begin
                        if (key_hit && lvl_changed) begin
                            btn_state_reg[btn_idx] <= lvl;
                        end
                    end
                    KIND_KEY_CAP: begin
                        if (key_in_range && present_reg && next_btn_reg != 10'd1023) begin
                            next_btn_reg <= next_btn_reg + 1'b1;
                        end
                    end
                    KIND_AXIS_CAP: begin
                        if (axis_in_range && present_reg) begin
                            axis_valid_reg[axis_code] <= 1'b1;
                            if (next_axis_reg != 7'd127) begin
                                next_axis_reg <= next_axis_reg + 1'b1;
                            end
                        end
                    end
                    KIND_DEADZONE: begin
                        if ({1'b0, code_reg} < 11'(AXIS_LIMIT)) begin
                            dead_reg[code_reg[AXL_IW-1:0]] <= band_reg;
                        end
                    end
                    default: ;
                endcase
            end
            if (state_reg == ST_FINISH && !drop) begin
                axis_nz_reg[aidx_reg] <= final_level != 16'd0;
            end
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg    <= kind_t'(s_tuser);
            code_reg    <= s_tdata[9:0];
            value_reg   <= s_tdata[41:10];
            present_reg <= s_tdata[42];
            lo_reg      <= s_tdata[74:43];
            hi_reg      <= s_tdata[106:75];
            band_reg    <= s_tdata[122:107];
        end
        if (state_reg == ST_LOOKUP) begin
            aidx_reg     <= axis_idx[AXL_IW-1:0];
            diff_reg     <= diff_c;
            den_reg      <= den_c;
            res_kind_reg <= EV_BUTTON;
            res_idx_reg  <= 5'(btn_idx);
            res_axis_reg <= '0;
            res_btn_reg  <= lvl;
        end
        if (state_reg == ST_PREP) begin
            absd_reg <= diff_reg[32] ? 32'(-diff_reg) : diff_reg[31:0];
            absn_reg <= den_reg[32] ? 32'(-den_reg) : den_reg[31:0];
            // zero range, zero offset or opposite signs all land on the minimum
            zero_reg <= (den_reg == '0) || (diff_reg == '0) || (diff_reg[32] != den_reg[32]);
        end
        if (state_reg == ST_FINISH) begin
            res_kind_reg <= EV_AXIS;
            res_idx_reg  <= 5'(aidx_reg);
            res_axis_reg <= final_level;
            res_btn_reg  <= '0;
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_kind_reg <= res_kind_reg;
            m_idx_reg  <= res_idx_reg;
            m_axis_reg <= res_axis_reg;
            m_btn_reg  <= res_btn_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {1'b0, m_btn_reg, m_axis_reg, m_idx_reg};

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_valid_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_kind_reg == EV_BUTTON || m_kind_reg == EV_AXIS))
        else $error("result word without an event kind");

    a_axis_no_button: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == EV_AXIS) |-> m_btn_reg == 2'd0)
        else $error("axis result carries a button level");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && m_valid_reg && !m_tready) |=> state_reg == ST_EMIT)
        else $error("result dropped while output register was full");

endmodule

// ----- hdl/jen_ram.sv -----
// generic single-write, single-read memory with registered read data
module jen_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/jen_div.sv -----
// restoring divider, one quotient bit per cycle, top bits flag overflow
module jen_div
    import jen_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output div_res_t         res
);

    localparam int DSR_W = DEN_W + DIV_STEPS - 1;

    logic [NUM_W-1:0]     rem_reg, rem_next;
    logic [DSR_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_STEPS-1:0] quot_reg, quot_next;
    logic [DIV_CW-1:0]    cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 ge;

    // trial subtract of the shifted divisor
    assign ge = {{(DSR_W - NUM_W){1'b0}}, rem_reg} >= dsr_reg;

    always_comb begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend;
            dsr_next  = {divisor, {(DIV_STEPS - 1){1'b0}}};
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = rem_reg - dsr_reg[NUM_W-1:0];
            end
            quot_next = {quot_reg[DIV_STEPS-2:0], ge};
            dsr_next  = dsr_reg >> 1;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quot_reg <= quot_next;
    end

    assign res.done   = done_reg;
    assign res.ovf    = quot_reg[DIV_STEPS-1] | quot_reg[DIV_STEPS-2];
    assign res.quot   = quot_reg[15:0];
    assign res.rem_nz = |rem_reg;

endmodule
